[rtl/bpc_pkg.sv]
// Shared widths and helpers for the pressure compensation block.
package bpc_pkg;
	localparam int unsigned W = 32;
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2 = 3'd3;
	localparam logic [2:0] REG_MC_MD = 3'd4;
	localparam logic [2:0] REG_OSS = 3'd5;
	localparam logic [16:0] P_MAX = 17'd131071;

	function automatic logic [W-1:0] sx16(input logic [15:0] h);
		sx16 = {{(W-16){h[15]}}, h};
	endfunction

	function automatic logic [W-1:0] asr(input logic [W-1:0] v, input int unsigned n);
		asr = W'($signed(v) >>> n);
	endfunction
endpackage

[rtl/bpc_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bpc_div #(
	parameter int SB = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [bpc_pkg::W-1:0]     num,
	input  logic [bpc_pkg::W-1:0]     den,
	input  logic [SB-1:0]             side,
	output logic                      out_valid,
	output logic [bpc_pkg::W-1:0]     quo,
	output logic [SB-1:0]             side_out
);
	import bpc_pkg::*;

	logic [W-1:0]  n_s [W+1];
	logic [W-1:0]  r_s [W+1];
	logic [W-1:0]  d_s [W+1];
	logic [SB-1:0] sb_s [W+1];
	logic          v_s [W+1];

	assign n_s[0]  = num;
	assign r_s[0]  = '0;
	assign d_s[0]  = den;
	assign sb_s[0] = side;
	assign v_s[0]  = in_valid;

	for (genvar k = 0; k < W; k++) begin : g_st
		logic [W:0] rt;
		logic [W:0] df;
		logic       ge;
		assign rt = {r_s[k], n_s[k][W-1]};
		assign df = rt - {1'b0, d_s[k]};
		assign ge = rt >= {1'b0, d_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1]  <= ge ? df[W-1:0] : rt[W-1:0];
				n_s[k+1]  <= {n_s[k][W-2:0], ge};
				d_s[k+1]  <= d_s[k];
				sb_s[k+1] <= sb_s[k];
			end
		end
	end

	assign out_valid = v_s[W];
	assign quo       = n_s[W];
	assign side_out  = sb_s[W];
endmodule

[rtl/barometric_pressure_compensation_top.sv]
// Top level of the barometric pressure compensation pipeline.
// One conversion enters per cycle while s_tready is high; the path runs through two
// 32-stage divider pipelines plus 14 arithmetic stages. The whole pipeline
// advances whenever the output stage is empty or its result is taken, so
// s_tready is low only while a finished result waits. Calibration writes
// take effect at once and are meant for an idle pipeline.
module barometric_pressure_compensation_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // raw_temp [15:0], press_msb [23:16], press_lsb [31:24], press_xlsb [39:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // pressure_pa[16:0], zero fill
	output logic        m_tuser,   // div_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import bpc_pkg::*;

	logic [31:0] ac1ac2_q, ac3ac4_q, ac5ac6_q, b1b2_q, mcmd_q;
	logic [1:0]  oss_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1ac2_q <= '0; ac3ac4_q <= '0; ac5ac6_q <= '0;
			b1b2_q <= '0; mcmd_q <= '0; oss_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AC1_AC2: ac1ac2_q <= cfg_data;
				REG_AC3_AC4: ac3ac4_q <= cfg_data;
				REG_AC5_AC6: ac5ac6_q <= cfg_data;
				REG_B1_B2:   b1b2_q <= cfg_data;
				REG_MC_MD:   mcmd_q <= cfg_data;
				REG_OSS:     oss_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(ac1ac2_q[31:16]);
	assign ac2 = sx16(ac1ac2_q[15:0]);
	assign ac3 = sx16(ac3ac4_q[31:16]);
	assign ac4 = {16'd0, ac3ac4_q[15:0]};
	assign ac5 = {16'd0, ac5ac6_q[31:16]};
	assign ac6 = {16'd0, ac5ac6_q[15:0]};
	assign b1  = sx16(b1b2_q[31:16]);
	assign b2  = sx16(b1b2_q[15:0]);
	assign mc  = sx16(mcmd_q[31:16]);
	assign md  = sx16(mcmd_q[15:0]);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13;
	logic d1_v, d2_v;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= d1_v; v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			v_s8 <= v_s7; v_s9 <= v_s8; v_s10 <= v_s9;
			v_s11 <= d2_v; v_s12 <= v_s11; v_s13 <= v_s12; m_tvalid <= v_s13;
		end
	end

	// stage 1: raw pressure assembly and temperature product
	logic [23:0]  raw;
	logic [W-1:0] prod_s1;
	logic [18:0]  up_s1;
	assign raw = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ({16'd0, s_tdata[15:0]} - ac6) * ac5;
			up_s1   <= 19'(raw >> (4'd8 - {2'b0, oss_q}));
		end
	end

	// stage 2: X1 and the first divisor
	logic [W-1:0] x1_s2, den_s2;
	logic [18:0]  up_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2  <= asr(prod_s1, 15);
			den_s2 <= asr(prod_s1, 15) + md;
			up_s2  <= up_s1;
		end
	end

	// stage 3: sign and magnitude for the divider
	logic [W-1:0] num2;
	logic [W-1:0] ma_s3, mb_s3, x1_s3;
	logic [18:0]  up_s3;
	logic         neg_s3, err_s3;
	assign num2 = mc << 11;
	always_ff @(posedge clk) begin
		if (en) begin
			ma_s3  <= num2[W-1] ? W'(0) - num2 : num2;
			mb_s3  <= den_s2[W-1] ? W'(0) - den_s2 : den_s2;
			neg_s3 <= num2[W-1] ^ den_s2[W-1];
			err_s3 <= den_s2 == '0;
			x1_s3  <= x1_s2;
			up_s3  <= up_s2;
		end
	end

	logic [W-1:0] q1;
	logic [18:0]  d1_up;
	logic [W-1:0] d1_x1;
	logic         d1_neg, d1_err;
	bpc_div #(.SB(53)) u_div_x2 (
		.clk, .arst_n, .en,
		.in_valid(v_s3), .num(ma_s3), .den(mb_s3),
		.side({up_s3, x1_s3, neg_s3, err_s3}),
		.out_valid(d1_v), .quo(q1), .side_out({d1_up, d1_x1, d1_neg, d1_err})
	);

	// stage 4: B6
	logic [W-1:0] b6_s4;
	logic [18:0]  up_s4;
	logic         err_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			b6_s4  <= d1_x1 + (d1_neg ? W'(0) - q1 : q1) - W'(4000);
			up_s4  <= d1_up;
			err_s4 <= d1_err;
		end
	end

	// stage 5: products on B6
	logic [W-1:0] sqf_s5, a2b6_s5, a3b6_s5;
	logic [18:0]  up_s5;
	logic         err_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			sqf_s5  <= b6_s4 * b6_s4;
			a2b6_s5 <= ac2 * b6_s4;
			a3b6_s5 <= ac3 * b6_s4;
			up_s5   <= up_s4;
			err_s5  <= err_s4;
		end
	end

	// stage 6: scaling
	logic [W-1:0] sq_s6, x2a_s6, x1c_s6;
	logic [18:0]  up_s6;
	logic         err_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s6  <= asr(sqf_s5, 12);
			x2a_s6 <= asr(a2b6_s5, 11);
			x1c_s6 <= asr(a3b6_s5, 13);
			up_s6  <= up_s5;
			err_s6 <= err_s5;
		end
	end

	// stage 7: B2 and B1 terms
	logic [W-1:0] b2sq_s7, b1sq_s7, x2a_s7, x1c_s7;
	logic [18:0]  up_s7;
	logic         err_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			b2sq_s7 <= b2 * sq_s6;
			b1sq_s7 <= b1 * sq_s6;
			x2a_s7  <= x2a_s6;
			x1c_s7  <= x1c_s6;
			up_s7   <= up_s6;
			err_s7  <= err_s6;
		end
	end

	// stage 8: B3 and the B4 factor
	logic [W-1:0] x3a, x3b, b3_s8, t_s8;
	logic [18:0]  up_s8;
	logic         err_s8;
	assign x3a = asr(b2sq_s7, 11) + x2a_s7;
	assign x3b = asr(x1c_s7 + asr(b1sq_s7, 16) + W'(2), 2);
	always_ff @(posedge clk) begin
		if (en) begin
			b3_s8  <= asr((((ac1 << 2) + x3a) << oss_q) + W'(2), 2);
			t_s8   <= x3b + W'(32768);
			up_s8  <= up_s7;
			err_s8 <= err_s7;
		end
	end

	// stage 9: B4 and UP-B3
	logic [W-1:0] b4p, b4_s9, dif_s9;
	logic         err_s9;
	assign b4p = ac4 * t_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			b4_s9  <= b4p >> 15;
			dif_s9 <= {13'd0, up_s8} - b3_s8;
			err_s9 <= err_s8;
		end
	end

	// stage 10: B7
	logic [W-1:0] b7_s10, b4_s10;
	logic         err_s10;
	always_ff @(posedge clk) begin
		if (en) begin
			b7_s10  <= dif_s9 * (W'(50000) >> oss_q);
			b4_s10  <= b4_s9;
			err_s10 <= err_s9 || (b4_s9 == '0);
		end
	end

	logic [W-1:0] q2;
	logic         d2_big, d2_err;
	bpc_div #(.SB(2)) u_div_p (
		.clk, .arst_n, .en,
		.in_valid(v_s10),
		.num(b7_s10[W-1] ? b7_s10 : b7_s10 << 1), .den(b4_s10),
		.side({b7_s10[W-1], err_s10}),
		.out_valid(d2_v), .quo(q2), .side_out({d2_big, d2_err})
	);

	// stage 11: raw pressure products
	logic [W-1:0] p, p8;
	logic [W-1:0] p_s11, p8sq_s11, m2_s11;
	logic         err_s11;
	assign p  = d2_big ? q2 << 1 : q2;
	assign p8 = asr(p, 8);
	always_ff @(posedge clk) begin
		if (en) begin
			p_s11    <= p;
			p8sq_s11 <= p8 * p8;
			m2_s11   <= (W'(0) - W'(7357)) * p;
			err_s11  <= d2_err;
		end
	end

	// stage 12: X1 scaling product
	logic [W-1:0] p_s12, m1_s12, x2_s12;
	logic         err_s12;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s12   <= p_s11;
			m1_s12  <= p8sq_s11 * W'(3038);
			x2_s12  <= asr(m2_s11, 16);
			err_s12 <= err_s11;
		end
	end

	// stage 13: final correction
	logic [W-1:0] pf_s13;
	logic         err_s13;
	always_ff @(posedge clk) begin
		if (en) begin
			pf_s13  <= p_s12 + asr(asr(m1_s12, 16) + x2_s12 + W'(3791), 4);
			err_s13 <= err_s12;
		end
	end

	// output register: saturation, zero on divide error or negative result
	logic [16:0] pa_q;
	logic        err_q;
	always_ff @(posedge clk) begin
		if (en) begin
			err_q <= err_s13;
			if (err_s13 || pf_s13[W-1]) pa_q <= '0;
			else if (pf_s13 > {15'd0, P_MAX}) pa_q <= P_MAX;
			else pa_q <= pf_s13[16:0];
		end
	end

	assign m_tdata = {7'd0, pa_q};
	assign m_tuser = err_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 24'd0)
		else $error("divide error with nonzero pressure");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready disagrees with pipeline advance");
endmodule
